### hdl/ipvtv_pkg.sv
`default_nettype none

package ipvtv_pkg;

	// token phase codes
	localparam logic [1:0] PH_BETWEEN = 2'd0;
	localparam logic [1:0] PH_SIGN    = 2'd1;
	localparam logic [1:0] PH_DIGITS  = 2'd2;
	localparam logic [1:0] PH_IGNORE  = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// limits and rejected addresses
	localparam logic [2:0]  TOKENS_MAX  = 3'd4;
	localparam logic [8:0]  OCTET_MAX   = 9'd255;
	localparam logic [11:0] ACC_SAT     = 12'd256;
	localparam logic [31:0] ADDR_BCAST  = 32'hFFFF_FFFF;
	localparam logic [31:0] ADDR_LOOP   = 32'h7F00_0001;

	// one input word: a character of the text
	typedef struct packed {
		logic [7:0] char_in;
		logic       last;
	} in_word_t;

	// one output word: the verdict
	typedef struct packed {
		logic        valid_res;
		logic [31:0] address;
	} out_word_t;

	// parser state carried between characters
	typedef struct packed {
		logic [2:0]  count;
		logic [1:0]  phase;
		logic [8:0]  acc;
		logic        neg;
		logic [31:0] addr;
		logic        bad;
		logic        ended;
	} tok_state_t;

endpackage

`default_nettype wire

### hdl/ipv4_text_validator_core.sv
// ipv4_text_validator_core
// Checks dotted-decimal IPv4 address text streamed one character per word.
// Input channel req/req_valid/req_ready carries char_in and last; output
// channel rsp/rsp_valid/rsp_ready carries valid_res and the packed address.
// Only a word with last set produces an output word; address is zero unless
// valid_res is set. A NUL character ends the text, and characters after it
// up to last are ignored.
// Throughput: one character per cycle while no unread verdict holds the input. The per-character parser
// update (one multiply-by-ten accumulate and compare) sits between the parser
// state registers and the output register.
// The verdict is registered and appears on rsp in the cycle after the last character is
// accepted.
// Stall: the output register holds its word until taken; req_ready is high
// only while the register is empty or being emptied in the same cycle, so
// any input word waits while a verdict sits unread.
// Reset: arst_n clears the parser state and empties the output register;
// the block takes input right after reset is released.
`default_nettype none

module ipv4_text_validator_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire ipvtv_pkg::in_word_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output ipvtv_pkg::out_word_t     rsp
);

	ipvtv_pkg::tok_state_t state_q;
	ipvtv_pkg::tok_state_t st_step;
	ipvtv_pkg::tok_state_t st_end;
	ipvtv_pkg::tok_state_t st_next;
	ipvtv_pkg::out_word_t  rsp_q;
	logic                  rsp_valid_q;
	logic                  req_fire;
	logic                  verdict;

	// close the open token: check its value and shift in the octet
	function automatic ipvtv_pkg::tok_state_t close_token(input ipvtv_pkg::tok_state_t s);
		ipvtv_pkg::tok_state_t r;
		r = s;
		case (s.phase)
			ipvtv_pkg::PH_SIGN: begin
				r.bad = 1'b1;
			end
			ipvtv_pkg::PH_DIGITS, ipvtv_pkg::PH_IGNORE: begin
				if (s.acc > ipvtv_pkg::OCTET_MAX || (s.neg && s.acc != 9'd0))
					r.bad = 1'b1;
				r.addr = {s.addr[23:0], s.acc[7:0]};
			end
			default: begin
			end
		endcase
		r.phase = ipvtv_pkg::PH_BETWEEN;
		return r;
	endfunction

	// take one ordinary character (not NUL, not dot)
	function automatic ipvtv_pkg::tok_state_t take_char(input ipvtv_pkg::tok_state_t s,
			input logic [7:0] c);
		ipvtv_pkg::tok_state_t r;
		logic                  is_digit;
		logic [3:0]            d;
		logic [11:0]           v;
		r        = s;
		is_digit = c inside {["0":"9"]};
		d        = 4'(c - ipvtv_pkg::CH_ZERO);
		v        = 12'(s.acc) * 12'd10 + 12'(d);
		case (s.phase)
			ipvtv_pkg::PH_BETWEEN: begin
				if (s.count >= ipvtv_pkg::TOKENS_MAX)
					r.bad = 1'b1;
				else
					r.count = s.count + 3'd1;
				r.acc = 9'd0;
				r.neg = 1'b0;
				if (c == ipvtv_pkg::CH_PLUS || c == ipvtv_pkg::CH_MINUS) begin
					r.neg   = (c == ipvtv_pkg::CH_MINUS);
					r.phase = ipvtv_pkg::PH_SIGN;
				end else if (is_digit) begin
					r.acc   = 9'(d);
					r.phase = ipvtv_pkg::PH_DIGITS;
				end else begin
					r.bad   = 1'b1;
					r.phase = ipvtv_pkg::PH_IGNORE;
				end
			end
			ipvtv_pkg::PH_SIGN: begin
				if (is_digit) begin
					r.acc   = 9'(d);
					r.phase = ipvtv_pkg::PH_DIGITS;
				end else begin
					r.bad   = 1'b1;
					r.phase = ipvtv_pkg::PH_IGNORE;
				end
			end
			ipvtv_pkg::PH_DIGITS: begin
				if (is_digit)
					r.acc = (v > ipvtv_pkg::ACC_SAT) ? 9'(ipvtv_pkg::ACC_SAT) : v[8:0];
				else
					r.phase = ipvtv_pkg::PH_IGNORE;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// handshake
	assign req_fire  = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// per-character update and end-of-text verdict
	always_comb begin
		st_step = state_q;
		if (!state_q.ended) begin
			if (req.char_in == ipvtv_pkg::CH_NUL) begin
				st_step       = close_token(state_q);
				st_step.ended = 1'b1;
			end else if (req.char_in == ipvtv_pkg::CH_DOT) begin
				st_step = close_token(state_q);
			end else begin
				st_step = take_char(state_q, req.char_in);
			end
		end
		st_end  = st_step.ended ? st_step : close_token(st_step);
		verdict = !st_end.bad && st_end.count == ipvtv_pkg::TOKENS_MAX &&
			st_end.addr != ipvtv_pkg::ADDR_BCAST && st_end.addr != ipvtv_pkg::ADDR_LOOP;
		st_next = req.last ? '0 : st_step;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (req_fire) begin
			state_q <= st_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire && req.last) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (req_fire && req.last) begin
			rsp_q.valid_res <= verdict;
			rsp_q.address   <= verdict ? st_end.addr : 32'd0;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count <= ipvtv_pkg::TOKENS_MAX)
		else $error("token count above four");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> req_ready)
		else $error("input stalled with empty output register");

	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.last |=> rsp_valid && state_q == '0)
		else $error("last word did not produce a verdict or clear the parser");

	a_rejected_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.valid_res |->
			rsp.address != ipvtv_pkg::ADDR_BCAST && rsp.address != ipvtv_pkg::ADDR_LOOP)
		else $error("broadcast or loopback reported valid");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.valid_res |-> rsp.address == 32'd0)
		else $error("invalid verdict with nonzero address");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int RANDOM_WORDS = 900;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	ipvtv_pkg::in_word_t  req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	ipvtv_pkg::out_word_t rsp;

	// parser state of the predictor and the verdicts it still owes
	ipvtv_pkg::tok_state_t parse_st;
	ipvtv_pkg::out_word_t  verdict_q[$];
	logic [7:0]            text_buf[$];

	int  words_sent;
	int  mismatch_count;
	int  stall_cycles;
	int  rsp_hold_len;
	bit  idle_on;
	ipvtv_pkg::out_word_t want;

	ipv4_text_validator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// close the open token and shift its octet into the address
	function automatic void octet_close();
		if (parse_st.phase == ipvtv_pkg::PH_SIGN) begin
			parse_st.bad = 1'b1;
		end else if (parse_st.phase == ipvtv_pkg::PH_DIGITS ||
				parse_st.phase == ipvtv_pkg::PH_IGNORE) begin
			if (parse_st.acc > ipvtv_pkg::OCTET_MAX || (parse_st.neg && parse_st.acc != '0))
				parse_st.bad = 1'b1;
			parse_st.addr = {parse_st.addr[23:0], parse_st.acc[7:0]};
		end
		parse_st.phase = ipvtv_pkg::PH_BETWEEN;
	endfunction

	// one non-separator character of a token
	function automatic void token_char(logic [7:0] c);
		logic       is_dig;
		logic [7:0] d;
		int         v;
		is_dig = (c >= ipvtv_pkg::CH_ZERO) && (c <= ipvtv_pkg::CH_ZERO + 8'd9);
		d = c - ipvtv_pkg::CH_ZERO;
		case (parse_st.phase)
			ipvtv_pkg::PH_BETWEEN: begin
				if (parse_st.count >= ipvtv_pkg::TOKENS_MAX)
					parse_st.bad = 1'b1;
				else
					parse_st.count = parse_st.count + 3'd1;
				parse_st.acc = '0;
				parse_st.neg = 1'b0;
				if (c == ipvtv_pkg::CH_PLUS || c == ipvtv_pkg::CH_MINUS) begin
					parse_st.neg = (c == ipvtv_pkg::CH_MINUS);
					parse_st.phase = ipvtv_pkg::PH_SIGN;
				end else if (is_dig) begin
					parse_st.acc = {5'd0, d[3:0]};
					parse_st.phase = ipvtv_pkg::PH_DIGITS;
				end else begin
					parse_st.bad = 1'b1;
					parse_st.phase = ipvtv_pkg::PH_IGNORE;
				end
			end
			ipvtv_pkg::PH_SIGN: begin
				if (is_dig) begin
					parse_st.acc = {5'd0, d[3:0]};
					parse_st.phase = ipvtv_pkg::PH_DIGITS;
				end else begin
					parse_st.bad = 1'b1;
					parse_st.phase = ipvtv_pkg::PH_IGNORE;
				end
			end
			ipvtv_pkg::PH_DIGITS: begin
				if (is_dig) begin
					v = parse_st.acc * 10 + d[3:0];
					if (v > ipvtv_pkg::ACC_SAT)
						v = ipvtv_pkg::ACC_SAT;
					parse_st.acc = v[8:0];
				end else begin
					parse_st.phase = ipvtv_pkg::PH_IGNORE;
				end
			end
			default: ;
		endcase
	endfunction

	// advance the predictor by one accepted word; a last word yields a verdict
	function automatic void parse_word(ipvtv_pkg::in_word_t w);
		logic ok;
		ipvtv_pkg::out_word_t v;
		if (!parse_st.ended) begin
			if (w.char_in == ipvtv_pkg::CH_NUL) begin
				octet_close();
				parse_st.ended = 1'b1;
			end else if (w.char_in == ipvtv_pkg::CH_DOT) begin
				octet_close();
			end else begin
				token_char(w.char_in);
			end
		end
		if (w.last) begin
			if (!parse_st.ended)
				octet_close();
			ok = !parse_st.bad && parse_st.count == ipvtv_pkg::TOKENS_MAX &&
				parse_st.addr != ipvtv_pkg::ADDR_BCAST && parse_st.addr != ipvtv_pkg::ADDR_LOOP;
			v.valid_res = ok;
			v.address = ok ? parse_st.addr : '0;
			verdict_q.push_back(v);
			// cleared state, phase back to between tokens
			parse_st = '0;
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
		mismatch_count++;
	endtask

	// offer one word and hold it until taken
	task automatic send_char(logic [7:0] c, logic lst);
		ipvtv_pkg::in_word_t w;
		int gap;
		w.char_in = c;
		w.last = lst;
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		parse_word(w);
		words_sent++;
		gap = idle_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// send the buffered text, last set on its final byte
	task automatic send_buf();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	task automatic load_string(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic send_text(string s);
		load_string(s);
		send_buf();
	endtask

	// one token: optional sign, decimal value, sometimes junk after it
	task automatic add_token();
		int r;
		int v;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 10)
			text_buf.push_back(ipvtv_pkg::CH_PLUS);
		else if (r < 16)
			text_buf.push_back(ipvtv_pkg::CH_MINUS);
		r = $urandom_range(0, 99);
		if (r < 50)
			v = $urandom_range(0, 255);
		else if (r < 60)
			v = 0;
		else if (r < 70)
			v = 255;
		else if (r < 75)
			v = 127;
		else if (r < 80)
			v = 1;
		else if (r < 86)
			v = $urandom_range(256, 99999);
		else
			v = $urandom_range(1, 9);
		if ($urandom_range(0, 99) < 8)
			text_buf.push_back(ipvtv_pkg::CH_ZERO);
		load_string($sformatf("%0d", v));
		if ($urandom_range(0, 99) < 6) begin
			b = $urandom_range(0, 255);
			text_buf.push_back(b);
		end
	endtask

	// random text: mostly well formed, some rejected classics, some noise
	task automatic build_random_text();
		string cs;
		int r;
		int n;
		logic [7:0] b;
		cs = "0123456789.+-";
		r = $urandom_range(0, 99);
		if (r < 4) begin
			load_string("127.0.0.1");
		end else if (r < 8) begin
			load_string("255.255.255.255");
		end else if (r < 80) begin
			n = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(0, 6);
			if ($urandom_range(0, 99) < 4)
				text_buf.push_back(ipvtv_pkg::CH_DOT);
			for (int k = 0; k < n; k++) begin
				if (k > 0) begin
					text_buf.push_back(ipvtv_pkg::CH_DOT);
					if ($urandom_range(0, 99) < 5)
						text_buf.push_back(ipvtv_pkg::CH_DOT);
				end
				add_token();
			end
			if ($urandom_range(0, 99) < 4)
				text_buf.push_back(ipvtv_pkg::CH_DOT);
		end else begin
			n = $urandom_range(1, 12);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 1) == 0)
					b = cs[$urandom_range(0, cs.len() - 1)];
				else
					b = $urandom_range(0, 255);
				text_buf.push_back(b);
			end
		end
		if (text_buf.size() == 0)
			text_buf.push_back(ipvtv_pkg::CH_DOT);
		// early end of text somewhere inside
		if ($urandom_range(0, 99) < 6)
			text_buf[$urandom_range(0, text_buf.size() - 1)] = ipvtv_pkg::CH_NUL;
	endtask

	task automatic test_valid_addresses();
		send_text("0.0.0.0");
		send_text("255.255.255.254");
		send_text("1..2.3.4.");
		send_text("+1.-0.3.4");
		send_text("1.2x.3.4");
		send_text("007.10.200.99");
	endtask

	task automatic test_rejected_addresses();
		send_text("255.255.255.255");
		send_text("127.0.0.1");
	endtask

	task automatic test_token_syntax();
		send_text("-1.2.3.4");
		send_text("1.+.3.4");
		send_text("1. 2.3.4");
		send_text("256.1.1.1");
		send_text("99999.1.1.1");
		send_text("a.1.2.3");
	endtask

	task automatic test_token_count();
		send_text("1.2.3.4.5");
		send_text("1.2.3");
		send_text(".");
		send_char(ipvtv_pkg::CH_NUL, 1'b1);
	endtask

	task automatic test_nul_end();
		// rest after the nul is ignored
		load_string("1.2.3.4");
		text_buf.push_back(ipvtv_pkg::CH_NUL);
		load_string("9.9");
		send_buf();
		load_string("1.2");
		text_buf.push_back(ipvtv_pkg::CH_NUL);
		load_string(".3.4");
		send_buf();
		// high bytes: ignored after digits, fatal at token start
		load_string("1.2.3.4");
		text_buf.push_back(8'hFF);
		send_buf();
		text_buf.push_back(8'h80);
		load_string(".1.2.3");
		send_buf();
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_backpressure();
		idle_on = 1'b0;
		rsp_hold_len = RSP_HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_text("1.2.3.4");
		for (int i = 0; i < 20; i++)
			send_char(ipvtv_pkg::CH_ZERO + i[3:0] % 10, 1'b1);
		idle_on = 1'b1;
	endtask

	task automatic test_random_texts();
		int start;
		int texts;
		start = words_sent;
		texts = 0;
		while (words_sent - start < RANDOM_WORDS) begin
			if (texts % 25 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			build_random_text();
			send_buf();
			texts++;
		end
		idle_on = 1'b1;
	endtask

	// receiver side: random stalls, plus a long hold on request
	initial begin : rsp_side
		int busy;
		int gap;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_len != 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_hold_len) @(posedge clk);
				rsp_hold_len = 0;
			end
			rsp_ready <= 1'b1;
			busy = $urandom_range(1, 12);
			repeat (busy) @(posedge clk);
			gap = idle_len();
			if (gap != 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// check each verdict word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected verdict", {31'd0, rsp.valid_res}, '0);
			end else begin
				want = verdict_q.pop_front();
				if (rsp.valid_res !== want.valid_res)
					report_mismatch("valid_res", {31'd0, rsp.valid_res},
						{31'd0, want.valid_res});
				if (rsp.address !== want.address)
					report_mismatch("address", rsp.address, want.address);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		parse_st = '0;
		words_sent = 0;
		mismatch_count = 0;
		rsp_hold_len = 0;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_valid_addresses();
		test_rejected_addresses();
		test_token_syntax();
		test_token_count();
		test_nul_end();
		test_backpressure();
		test_random_texts();
		req_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
